// ----- rtl/osw_pkg.sv -----
package osw_pkg;

  // fixed widths of the datapath
  localparam int unsigned ExtW   = 31;  // unsigned Q15.16 extent
  localparam int unsigned QuatW  = 16;  // signed Q2.14 quaternion part
  localparam int unsigned CrdW   = 32;  // signed Q16.16 coordinate
  localparam int unsigned SqW    = 32;  // product of two quaternion parts
  localparam int unsigned MatW   = 34;  // signed rotation entry, Q.28
  localparam int unsigned MagW   = 33;  // magnitude of a rotation entry, up to 2^32
  localparam int unsigned HalfW  = 33;  // half size, Q.17
  localparam int unsigned HalfLoW = 17; // low slice of a half size per multiplier
  localparam int unsigned HalfHiW = HalfW - HalfLoW;
  localparam int unsigned PlW    = MagW + HalfLoW;
  localparam int unsigned PhW    = MagW + HalfHiW;
  localparam int unsigned ProdW  = MagW + HalfW;  // |m| * h, Q.45
  localparam int unsigned SumW   = ProdW + 2;     // three products plus bias
  localparam int unsigned RndShift = 29;          // Q.45 to Q16.16
  localparam int unsigned RadW   = SumW - RndShift;
  localparam int unsigned EdgeW  = RadW + 2;      // pos +/- radius, signed

  typedef enum logic [2:0] {
    SHAPE_BOX      = 3'd0,
    SHAPE_SPHERE   = 3'd1,
    SHAPE_CAPSULE  = 3'd2,
    SHAPE_CYLINDER = 3'd3,
    SHAPE_NONE     = 3'd4
  } shape_kind_e;

  typedef struct packed {
    logic [2:0]              shape_kind;
    logic [ExtW-1:0]         ext_a;
    logic [ExtW-1:0]         ext_b;
    logic [ExtW-1:0]         ext_c;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
    logic signed [QuatW-1:0] quat_w;
    logic signed [CrdW-1:0]  pos_x;
    logic signed [CrdW-1:0]  pos_y;
    logic signed [CrdW-1:0]  pos_z;
  } in_req_t;

  typedef struct packed {
    logic [2:0][2:0][MagW-1:0] mag;
    logic [2:0][HalfW-1:0]     half;
    logic [2:0][CrdW-1:0]      pos;
  } mat_t;

  typedef struct packed {
    logic [2:0][2:0][ProdW-1:0] prod;
    logic [2:0][CrdW-1:0]       pos;
  } prod_t;

  typedef struct packed {
    logic signed [CrdW-1:0] min_x;
    logic signed [CrdW-1:0] min_y;
    logic signed [CrdW-1:0] min_z;
    logic signed [CrdW-1:0] max_x;
    logic signed [CrdW-1:0] max_y;
    logic signed [CrdW-1:0] max_z;
  } out_rsp_t;

endpackage

// ----- rtl/osw_if.sv -----
// input channel: one shape record per request
interface osw_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         shape_kind;
  logic [30:0]        ext_a;
  logic [30:0]        ext_b;
  logic [30:0]        ext_c;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (
    output valid, shape_kind, ext_a, ext_b, ext_c,
           quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, shape_kind, ext_a, ext_b, ext_c,
           quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

// output channel: one world box per request
interface osw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] min_z;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  logic signed [31:0] max_z;

  modport source (
    output valid, min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

// ----- rtl/osw_quat_mat.sv -----
module osw_quat_mat (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  osw_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output osw_pkg::mat_t    out_mat_o
);
  import osw_pkg::*;

  // stage a: quaternion products and half sizes
  logic              a_valid_q, a_ready;
  logic [SqW-1:0]    xx_d, yy_d, zz_d, ww_d, xy_d, xz_d, yz_d, wx_d, wy_d, wz_d;
  logic [SqW-1:0]    xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic [2:0][HalfW-1:0] half_d, half_q;
  logic [2:0][CrdW-1:0]  pos_q;

  // stage b: matrix magnitudes
  logic              b_valid_q, b_ready;
  mat_t              mat_d, mat_q;

  logic [HalfW-1:0]  a2, b1;
  logic [MatW-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  function automatic logic [MatW-1:0] sx(input logic [SqW-1:0] v);
    sx = {{(MatW-SqW){v[SqW-1]}}, v};
  endfunction

  function automatic logic [MagW-1:0] mag_of(input logic [MatW-1:0] v);
    logic [MatW-1:0] n;
    n = v[MatW-1] ? (~v + MatW'(1)) : v;
    mag_of = n[MagW-1:0];
  endfunction

  // half sizes in Q.17 by shape kind
  assign a2 = {1'b0, in_req_i.ext_a, 1'b0};
  assign b1 = {2'b00, in_req_i.ext_b};
  always_comb begin
    case (shape_kind_e'(in_req_i.shape_kind))
      SHAPE_BOX: begin
        half_d[0] = a2;
        half_d[1] = {1'b0, in_req_i.ext_b, 1'b0};
        half_d[2] = {1'b0, in_req_i.ext_c, 1'b0};
      end
      SHAPE_SPHERE: begin
        half_d[0] = a2;
        half_d[1] = a2;
        half_d[2] = a2;
      end
      SHAPE_CAPSULE: begin
        half_d[0] = a2;
        half_d[1] = b1 + a2;
        half_d[2] = a2;
      end
      SHAPE_CYLINDER: begin
        half_d[0] = a2;
        half_d[1] = b1;
        half_d[2] = a2;
      end
      default: begin
        half_d = '0;
      end
    endcase
  end

  // signed quaternion products
  assign xx_d = in_req_i.quat_x * in_req_i.quat_x;
  assign yy_d = in_req_i.quat_y * in_req_i.quat_y;
  assign zz_d = in_req_i.quat_z * in_req_i.quat_z;
  assign ww_d = in_req_i.quat_w * in_req_i.quat_w;
  assign xy_d = in_req_i.quat_x * in_req_i.quat_y;
  assign xz_d = in_req_i.quat_x * in_req_i.quat_z;
  assign yz_d = in_req_i.quat_y * in_req_i.quat_z;
  assign wx_d = in_req_i.quat_w * in_req_i.quat_x;
  assign wy_d = in_req_i.quat_w * in_req_i.quat_y;
  assign wz_d = in_req_i.quat_w * in_req_i.quat_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      xx_q <= xx_d; yy_q <= yy_d; zz_q <= zz_d; ww_q <= ww_d;
      xy_q <= xy_d; xz_q <= xz_d; yz_q <= yz_d;
      wx_q <= wx_d; wy_q <= wy_d; wz_q <= wz_d;
      half_q <= half_d;
      pos_q[0] <= in_req_i.pos_x;
      pos_q[1] <= in_req_i.pos_y;
      pos_q[2] <= in_req_i.pos_z;
    end
  end

  // rotation matrix of v' = q v q*, Q.28, two's complement
  assign m00 = sx(xx_q) + sx(ww_q) - sx(yy_q) - sx(zz_q);
  assign m01 = (sx(xy_q) - sx(wz_q)) << 1;
  assign m02 = (sx(xz_q) + sx(wy_q)) << 1;
  assign m10 = (sx(wz_q) + sx(xy_q)) << 1;
  assign m11 = sx(ww_q) - sx(xx_q) + sx(yy_q) - sx(zz_q);
  assign m12 = (sx(yz_q) - sx(wx_q)) << 1;
  assign m20 = (sx(xz_q) - sx(wy_q)) << 1;
  assign m21 = (sx(wx_q) + sx(yz_q)) << 1;
  assign m22 = sx(ww_q) - sx(xx_q) - sx(yy_q) + sx(zz_q);

  always_comb begin
    mat_d.mag[0][0] = mag_of(m00);
    mat_d.mag[0][1] = mag_of(m01);
    mat_d.mag[0][2] = mag_of(m02);
    mat_d.mag[1][0] = mag_of(m10);
    mat_d.mag[1][1] = mag_of(m11);
    mat_d.mag[1][2] = mag_of(m12);
    mat_d.mag[2][0] = mag_of(m20);
    mat_d.mag[2][1] = mag_of(m21);
    mat_d.mag[2][2] = mag_of(m22);
    mat_d.half      = half_q;
    mat_d.pos       = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      mat_q <= mat_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_mat_o   = mat_q;

endmodule

// ----- rtl/osw_ext_mul.sv -----
module osw_ext_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  osw_pkg::mat_t  in_mat_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output osw_pkg::prod_t out_prod_o
);
  import osw_pkg::*;

  // stage c: split products |m| * h_lo and |m| * h_hi
  logic                     c_valid_q, c_ready;
  logic [2:0][2:0][PlW-1:0] pl_d, pl_q;
  logic [2:0][2:0][PhW-1:0] ph_d, ph_q;
  logic [2:0][CrdW-1:0]     pos_q;

  // stage d: recombined 66-bit products
  logic                     d_valid_q, d_ready;
  prod_t                    prod_d, prod_q;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  // nine entries, two narrow multipliers each
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pl_d[i][j] = PlW'(in_mat_i.mag[i][j]) * PlW'(in_mat_i.half[j][HalfLoW-1:0]);
        ph_d[i][j] = PhW'(in_mat_i.mag[i][j]) * PhW'(in_mat_i.half[j][HalfW-1:HalfLoW]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      pl_q  <= pl_d;
      ph_q  <= ph_d;
      pos_q <= in_mat_i.pos;
    end
  end

  // recombine the halves of each product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d.prod[i][j] = ProdW'(pl_q[i][j]) + {ph_q[i][j], {HalfLoW{1'b0}}};
      end
    end
    prod_d.pos = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (d_ready) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && c_valid_q) begin
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_prod_o  = prod_q;

endmodule

// ----- rtl/osw_bound.sv -----
module osw_bound (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  osw_pkg::prod_t    in_prod_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output osw_pkg::out_rsp_t out_rsp_o
);
  import osw_pkg::*;

  localparam logic [SumW-1:0] RndBias = SumW'(1) << (RndShift - 1);
  localparam logic [CrdW-1:0] SatMax  = {1'b0, {(CrdW-1){1'b1}}};
  localparam logic [CrdW-1:0] SatMin  = {1'b1, {(CrdW-1){1'b0}}};

  // stage e: rounded radius per axis
  logic                  e_valid_q, e_ready;
  logic [2:0][SumW-1:0]  sum;
  logic [2:0][RadW-1:0]  rad_d, rad_q;
  logic [2:0][CrdW-1:0]  pos_q;

  // stage f: output register
  logic                  f_valid_q, f_ready;
  logic [2:0][EdgeW-1:0] lo_v, hi_v;
  logic [2:0][CrdW-1:0]  lo_s, hi_s;
  out_rsp_t              rsp_d, rsp_q;

  assign f_ready    = !f_valid_q || out_ready_i;
  assign e_ready    = !e_valid_q || f_ready;
  assign in_ready_o = e_ready;

  function automatic logic [CrdW-1:0] sat(input logic [EdgeW-1:0] v);
    if (v[EdgeW-1:CrdW-1] == '0 || v[EdgeW-1:CrdW-1] == '1) begin
      sat = v[CrdW-1:0];
    end else if (v[EdgeW-1]) begin
      sat = SatMin;
    end else begin
      sat = SatMax;
    end
  endfunction

  // row sum of |m| * h, round half up to Q16.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SumW'(in_prod_i.prod[i][0]) + SumW'(in_prod_i.prod[i][1])
             + SumW'(in_prod_i.prod[i][2]) + RndBias;
      rad_d[i] = sum[i][SumW-1:RndShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (e_ready) begin
      e_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && in_valid_i) begin
      rad_q <= rad_d;
      pos_q <= in_prod_i.pos;
    end
  end

  // pos -/+ radius, saturated to 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_v[i] = {{(EdgeW-CrdW){pos_q[i][CrdW-1]}}, pos_q[i]} - {2'b00, rad_q[i]};
      hi_v[i] = {{(EdgeW-CrdW){pos_q[i][CrdW-1]}}, pos_q[i]} + {2'b00, rad_q[i]};
      lo_s[i] = sat(lo_v[i]);
      hi_s[i] = sat(hi_v[i]);
    end
    rsp_d.min_x = lo_s[0];
    rsp_d.min_y = lo_s[1];
    rsp_d.min_z = lo_s[2];
    rsp_d.max_x = hi_s[0];
    rsp_d.max_y = hi_s[1];
    rsp_d.max_z = hi_s[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (f_ready) begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ready && e_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = f_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- rtl/oriented_shape_world_aabb_unit.sv -----
// World-space bounding box of a rotated shape.
// in_i takes one shape record per request: kind, extents (Q15.16), a
// rotation quaternion (Q2.14, used unnormalized) and a world position.
// out_o returns one box per request: per-axis min and max in Q16.16,
// saturated to the signed 32-bit range. Results leave in request order.
// Both channels use valid/ready; a request moves on a clock edge where
// both are high.
// The path from an accepted request to valid on out_o runs through
// six register stages (quaternion products, matrix magnitudes,
// split extent multiplies, product recombine, rounded row sums,
// saturated min/max in the output register).
// Throughput: one request per cycle unless out_o stalls; every stage is
// a valid register with its own ready, so empty stages fill while the
// output waits. When out_o stalls, results collect in the stages and
// in_i.ready drops only once all six stages hold a request; nothing
// is dropped or doubled. Reset (rst_ni low, asynchronous) empties the
// pipeline; no state links one request to the next.
module oriented_shape_world_aabb_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  osw_in_if.sink    in_i,
  osw_out_if.source out_o
);
  import osw_pkg::*;

  in_req_t  in_req;
  mat_t     mat;
  prod_t    prod;
  out_rsp_t rsp;
  logic     mat_valid, mat_ready;
  logic     prod_valid, prod_ready;

  // gather the request fields
  always_comb begin
    in_req.shape_kind = in_i.shape_kind;
    in_req.ext_a      = in_i.ext_a;
    in_req.ext_b      = in_i.ext_b;
    in_req.ext_c      = in_i.ext_c;
    in_req.quat_x     = in_i.quat_x;
    in_req.quat_y     = in_i.quat_y;
    in_req.quat_z     = in_i.quat_z;
    in_req.quat_w     = in_i.quat_w;
    in_req.pos_x      = in_i.pos_x;
    in_req.pos_y      = in_i.pos_y;
    in_req.pos_z      = in_i.pos_z;
  end

  osw_quat_mat u_quat_mat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_req_i    (in_req),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .out_mat_o   (mat)
  );

  osw_ext_mul u_ext_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .in_mat_i    (mat),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_prod_o  (prod)
  );

  osw_bound u_bound (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_ready_o  (prod_ready),
    .in_prod_i   (prod),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_rsp_o   (rsp)
  );

  // drive the result fields
  assign out_o.min_x = rsp.min_x;
  assign out_o.min_y = rsp.min_y;
  assign out_o.min_z = rsp.min_z;
  assign out_o.max_x = rsp.max_x;
  assign out_o.max_y = rsp.max_y;
  assign out_o.max_z = rsp.max_z;

endmodule

// ----- test/oriented_shape_world_aabb_unit_tb.sv -----
`timescale 1ns / 100ps

module oriented_shape_world_aabb_unit_tb;
  import osw_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomShapes = 1000;
  localparam int unsigned IdlePct = 8;
  localparam int unsigned CalmFrom = 400;
  localparam int unsigned CalmTo = 700;
  localparam longint CrdMax = 64'sd2147483647;
  localparam longint CrdMin = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni;

  osw_in_if  in_ch();
  osw_out_if out_ch();

  in_req_t  pending_shapes [$];
  out_rsp_t expected_boxes [$];

  int unsigned mismatch_cnt = 0;
  int unsigned shapes_sent = 0;
  int unsigned boxes_seen = 0;
  int unsigned cycle_cnt = 0;

  oriented_shape_world_aabb_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // clamp to the signed 32-bit coordinate range
  function automatic logic [CrdW-1:0] clamp_crd(longint v);
    if (v > CrdMax) return CrdMax[CrdW-1:0];
    if (v < CrdMin) return CrdMin[CrdW-1:0];
    return v[CrdW-1:0];
  endfunction

  // world box of one shape: pos -/+ sum_j |rot[i][j]| * half[j], rounded once
  function automatic out_rsp_t world_box(in_req_t req);
    logic [HalfW-1:0] half_v [3];
    longint qx, qy, qz, qw;
    longint rot [3][3];
    longint pos_v [3];
    longint rad;
    logic [63:0] mag_v;
    logic [127:0] acc;
    logic [CrdW-1:0] lo_v [3];
    logic [CrdW-1:0] hi_v [3];
    out_rsp_t box;

    // local half sizes, Q.17
    case (req.shape_kind)
      SHAPE_BOX: begin
        half_v[0] = {1'b0, req.ext_a, 1'b0};
        half_v[1] = {1'b0, req.ext_b, 1'b0};
        half_v[2] = {1'b0, req.ext_c, 1'b0};
      end
      SHAPE_SPHERE: begin
        half_v[0] = {1'b0, req.ext_a, 1'b0};
        half_v[1] = {1'b0, req.ext_a, 1'b0};
        half_v[2] = {1'b0, req.ext_a, 1'b0};
      end
      SHAPE_CAPSULE: begin
        half_v[0] = {1'b0, req.ext_a, 1'b0};
        half_v[1] = {2'b0, req.ext_b} + {1'b0, req.ext_a, 1'b0};
        half_v[2] = {1'b0, req.ext_a, 1'b0};
      end
      SHAPE_CYLINDER: begin
        half_v[0] = {1'b0, req.ext_a, 1'b0};
        half_v[1] = {2'b0, req.ext_b};
        half_v[2] = {1'b0, req.ext_a, 1'b0};
      end
      default: begin
        half_v[0] = '0;
        half_v[1] = '0;
        half_v[2] = '0;
      end
    endcase

    // rotation matrix of the unnormalized quaternion, Q.28
    qx = req.quat_x;
    qy = req.quat_y;
    qz = req.quat_z;
    qw = req.quat_w;
    rot[0][0] = qx * qx + qw * qw - qy * qy - qz * qz;
    rot[0][1] = 2 * qx * qy - 2 * qw * qz;
    rot[0][2] = 2 * qx * qz + 2 * qw * qy;
    rot[1][0] = 2 * qw * qz + 2 * qx * qy;
    rot[1][1] = qw * qw - qx * qx + qy * qy - qz * qz;
    rot[1][2] = 2 * qy * qz - 2 * qw * qx;
    rot[2][0] = 2 * qx * qz - 2 * qw * qy;
    rot[2][1] = 2 * qw * qx + 2 * qy * qz;
    rot[2][2] = qw * qw - qx * qx - qy * qy + qz * qz;

    pos_v[0] = req.pos_x;
    pos_v[1] = req.pos_y;
    pos_v[2] = req.pos_z;

    // exact radius per axis, round half up from Q.45 to Q16.16
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
        mag_v = (rot[i][j] < 0) ? -rot[i][j] : rot[i][j];
        acc = acc + ({64'd0, mag_v} * {95'd0, half_v[j]});
      end
      acc = acc + (128'd1 << (RndShift - 1));
      rad = longint'({1'b0, acc[RndShift +: 63]});
      lo_v[i] = clamp_crd(pos_v[i] - rad);
      hi_v[i] = clamp_crd(pos_v[i] + rad);
    end

    box.min_x = lo_v[0];
    box.min_y = lo_v[1];
    box.min_z = lo_v[2];
    box.max_x = hi_v[0];
    box.max_y = hi_v[1];
    box.max_z = hi_v[2];
    return box;
  endfunction

  task automatic add_shape(logic [2:0] kind, logic [ExtW-1:0] a, logic [ExtW-1:0] b,
                           logic [ExtW-1:0] c, logic [QuatW-1:0] qx, logic [QuatW-1:0] qy,
                           logic [QuatW-1:0] qz, logic [QuatW-1:0] qw, logic [CrdW-1:0] px,
                           logic [CrdW-1:0] py, logic [CrdW-1:0] pz);
    in_req_t req;
    req.shape_kind = kind;
    req.ext_a = a;
    req.ext_b = b;
    req.ext_c = c;
    req.quat_x = qx;
    req.quat_y = qy;
    req.quat_z = qz;
    req.quat_w = qw;
    req.pos_x = px;
    req.pos_y = py;
    req.pos_z = pz;
    pending_shapes.push_back(req);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    in_req_t cur;
    logic fire;
    logic gap;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        cur = '{shape_kind: in_ch.shape_kind, ext_a: in_ch.ext_a, ext_b: in_ch.ext_b,
                ext_c: in_ch.ext_c, quat_x: in_ch.quat_x, quat_y: in_ch.quat_y,
                quat_z: in_ch.quat_z, quat_w: in_ch.quat_w, pos_x: in_ch.pos_x,
                pos_y: in_ch.pos_y, pos_z: in_ch.pos_z};
        expected_boxes.push_back(world_box(cur));
        shapes_sent <= shapes_sent + 1;
      end
      gap = !(shapes_sent >= CalmFrom && shapes_sent < CalmTo) &&
            ($urandom_range(0, 99) < IdlePct);
      if (!in_ch.valid || fire) begin
        if (pending_shapes.size() > 0 && !gap) begin
          cur = pending_shapes.pop_front();
          in_ch.shape_kind <= cur.shape_kind;
          in_ch.ext_a <= cur.ext_a;
          in_ch.ext_b <= cur.ext_b;
          in_ch.ext_c <= cur.ext_c;
          in_ch.quat_x <= cur.quat_x;
          in_ch.quat_y <= cur.quat_y;
          in_ch.quat_z <= cur.quat_z;
          in_ch.quat_w <= cur.quat_w;
          in_ch.pos_x <= cur.pos_x;
          in_ch.pos_y <= cur.pos_y;
          in_ch.pos_z <= cur.pos_z;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t got_box;
    out_rsp_t exp_box;
    logic [5:0][CrdW-1:0] got_w;
    logic [5:0][CrdW-1:0] exp_w;
    string field_names [6];
    field_names = '{"max_z", "max_y", "max_x", "min_z", "min_y", "min_x"};
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_box = '{min_x: out_ch.min_x, min_y: out_ch.min_y, min_z: out_ch.min_z,
                    max_x: out_ch.max_x, max_y: out_ch.max_y, max_z: out_ch.max_z};
        boxes_seen <= boxes_seen + 1;
        if (expected_boxes.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          $display("%0t: unexpected box, expected none, actual %h", $time, got_box);
        end else begin
          exp_box = expected_boxes.pop_front();
          got_w = got_box;
          exp_w = exp_box;
          if (got_w != exp_w) begin
            mismatch_cnt <= mismatch_cnt + 1;
            for (int k = 0; k < 6; k++) begin
              if (got_w[k] != exp_w[k])
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, field_names[k], exp_w[k], got_w[k]);
            end
          end
        end
      end
      out_ch.ready <= (boxes_seen >= CalmFrom && boxes_seen < CalmTo) ||
                      ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    logic [2:0] kind;
    logic [ExtW-1:0] ea, eb, ec;
    logic [QuatW-1:0] q [4];
    logic [CrdW-1:0] p [3];

    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.shape_kind = '0;
    in_ch.ext_a = '0;
    in_ch.ext_b = '0;
    in_ch.ext_c = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.quat_w = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b0;

    // directed shapes: every kind, field extremes, rounding and saturation
    add_shape(SHAPE_BOX, 31'h10000, 31'h20000, 31'h30000, 16'h0, 16'h0, 16'h0, 16'h4000,
              32'h0, 32'h0, 32'h0);
    add_shape(SHAPE_BOX, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    add_shape(SHAPE_BOX, '1, '1, '1, 16'h0, 16'h0, 16'h0, 16'h4000, '0, '0, '0);
    add_shape(SHAPE_BOX, '1, '1, '1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, '0, '0, '0);
    add_shape(SHAPE_BOX, '1, '1, '1, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              32'h7fffffff, 32'h80000000, 32'hffffffff);
    add_shape(SHAPE_SPHERE, 31'h18000, '1, '1, 16'h0, 16'h0, 16'h0, 16'h4000,
              32'h100000, 32'hfff00000, 32'h0);
    add_shape(SHAPE_CAPSULE, 31'h8000, 31'h30001, '1, 16'h0, 16'h0, 16'h0, 16'h4000,
              '0, '0, '0);
    add_shape(SHAPE_CYLINDER, 31'h8000, 31'h30001, '1, 16'h0, 16'h0, 16'h0, 16'h4000,
              '0, '0, '0);
    add_shape(SHAPE_NONE, '1, '1, '1, 16'h1234, 16'h8000, 16'h7fff, 16'h4000,
              32'h12345678, 32'h87654321, 32'h0);
    add_shape(3'd5, '1, '1, '1, 16'h4000, 16'h0, 16'h0, 16'h0, 32'h1, 32'h2, 32'h3);
    add_shape(3'd6, 31'h55555555, 31'h2aaaaaaa, '1, 16'h7fff, 16'h7fff, 16'h0, 16'h0,
              32'hffffffff, 32'h0, 32'h1);
    add_shape(3'd7, '1, '0, '1, 16'h8000, 16'h0, 16'h8000, 16'h0, '0, '0, '0);
    // zero quaternion collapses any box
    add_shape(SHAPE_BOX, '1, '1, '1, '0, '0, '0, '0, 32'h00010000, 32'h0, 32'hffff0000);
    // max and min saturation at the position extremes
    add_shape(SHAPE_SPHERE, 31'h10000, '0, '0, 16'h0, 16'h0, 16'h0, 16'h4000,
              32'h7fffffff, 32'h7fff0000, 32'h7ffff000);
    add_shape(SHAPE_SPHERE, 31'h10000, '0, '0, 16'h0, 16'h0, 16'h0, 16'h4000,
              32'h80000000, 32'h8000ffff, 32'h80000fff);
    // quarter turn about z and half turn about x
    add_shape(SHAPE_BOX, 31'h10000, 31'h40000, 31'h20000, 16'h0, 16'h0, 16'h2d41, 16'h2d41,
              32'h00050000, '0, '0);
    add_shape(SHAPE_BOX, 31'h10000, 31'h40000, 31'h20000, 16'h8000, 16'h0, 16'h0, 16'h0,
              '0, 32'h00050000, '0);
    // single lsb extents with odd rotations for rounding, then alternating bit patterns
    add_shape(SHAPE_BOX, 31'h1, 31'h1, 31'h1, 16'h1, 16'h2001, 16'hffff, 16'h3fff,
              '0, '0, '0);
    add_shape(SHAPE_CAPSULE, 31'h1, 31'h1, '0, 16'h0, 16'h0, 16'h0, 16'h4000,
              32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    add_shape(SHAPE_CYLINDER, '1, '1, 31'h0, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
              32'h55555555, 32'haaaaaaaa, 32'h55555555);

    // random shapes
    for (int n = 0; n < RandomShapes; n++) begin
      pick = $urandom_range(0, 19);
      kind = (pick < 18) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
      ea = ExtW'($urandom() >> $urandom_range(1, 31));
      eb = ExtW'($urandom() >> $urandom_range(1, 31));
      ec = ExtW'($urandom() >> $urandom_range(1, 31));
      pick = $urandom_range(0, 9);
      for (int k = 0; k < 4; k++) begin
        if (pick < 6)
          q[k] = QuatW'(int'($urandom_range(0, 32768)) - 16384);
        else if (pick < 9)
          q[k] = QuatW'($urandom());
        else
          q[k] = '0;
      end
      // axis-aligned orientation
      if (pick == 9)
        q[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 9) < 7)
          p[k] = CrdW'(int'($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
        else
          p[k] = $urandom();
      end
      add_shape(kind, ea, eb, ec, q[0], q[1], q[2], q[3], p[0], p[1], p[2]);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_shapes.size() > 0 || in_ch.valid || expected_boxes.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
